// ----- sv/dwls_pkg.sv -----
package dwls_pkg;

    // command codes carried in the opcode field
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    // configuration register indexes
    localparam logic CFG_HIGHEST_SEQ  = 1'b0;
    localparam logic CFG_VISIBLE_MASK = 1'b1;

    localparam int SEQ_W    = 6;
    localparam int MASK_W   = 64;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 16;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_CMD   = 3'd1,
        STAT_BAD_SEQ   = 3'd2,
        STAT_INS_OPEN  = 3'd3,
        STAT_DEL_OPEN  = 3'd4,
        STAT_UNMATCHED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_OUT
    } t_state;

    // one stored entry per sequence
    typedef struct packed {
        logic open;
        logic is_ins;
    } t_entry;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic             clr;
        logic             smp;
        logic [SEQ_W-1:0] idx;
        logic             vis;
    } t_scan_ctl;

    typedef struct packed {
        logic             keep;
        logic [SEQ_W-1:0] owner;
    } t_scan_res;

endpackage

// ----- sv/dwls_slot_mem.sv -----
module dwls_slot_mem
    import dwls_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry             mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // per-entry valid bits stand in for the all-zero reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- sv/dwls_scan.sv -----
module dwls_scan
    import dwls_pkg::*;
(
    input  logic      i_clk,
    input  t_scan_ctl i_ctl,
    input  t_entry    i_entry,
    output t_scan_res o_res
);

    logic [SEQ_W-1:0] r_hi_ins;
    logic [SEQ_W-1:0] r_hi_del;
    logic [SEQ_W-1:0] r_hi_hid;

    // entries arrive in rising order, so a hit simply replaces the maximum
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_hi_ins <= '0;
            r_hi_del <= '0;
            r_hi_hid <= '0;
        end else if (i_ctl.smp && i_entry.open) begin
            if (i_entry.is_ins) begin
                if (i_ctl.vis) begin
                    r_hi_ins <= i_ctl.idx;
                end else begin
                    r_hi_hid <= i_ctl.idx;
                end
            end else if (i_ctl.vis) begin
                r_hi_del <= i_ctl.idx;
            end
        end
    end

    always_comb begin
        o_res.owner = r_hi_ins;
        if (r_hi_del > r_hi_ins) begin
            o_res.keep = 1'b0;
        end else if (r_hi_ins > r_hi_hid) begin
            o_res.keep = 1'b1;
        end else begin
            o_res.keep = 1'b0;
        end
    end

endmodule

// ----- sv/delta_weave_line_selector_core.sv -----
// weave control event selector
// input stream: one beat per control event, tdata = {seq_num, opcode}.
// output stream: one beat per event, tdata = {owner_seq, keep_lines, status}.
// config channel: i_cfg_index 0 writes highest_seq (low 6 bits of data),
// index 1 writes visible_mask; always ready, write only while idle.
// per-sequence open flag and kind live in a one-port-read, one-port-write
// memory with a registered read. an accepted event reads its entry, checks
// it and writes it back, then the entries 0..top are read one per cycle
// (top = min(highest_seq, SEQ_SLOTS-1)) and the decision is formed.
// a good event steps from idle through lookup, check, scan, drain and
// decide to the output state; one rejected on opcode or range goes from
// idle straight to output, one rejected on the entry check from check.
// the next input beat is taken in the cycle after the result is loaded.
// only one event is worked on at a time; a finished result sits in the
// output register so the next beat is taken while it waits.
// when the receiver stalls, the next result holds in the sequencer until
// the output register frees, and input tready stays low meanwhile.
// reset clears all entries (through per-entry valid bits, no sweep), the
// keep flag, the owner, highest_seq to 63 and visible_mask to zero.
module delta_weave_line_selector_core
    import dwls_pkg::*;
#(
    parameter int SEQ_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // opcode[1:0], seq_num[7:2]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // status[2:0], keep_lines[3], owner_seq[9:4]
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [MASK_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
    localparam logic [SEQ_W:0] LAST_SLOT = (SEQ_W+1)'(SEQ_SLOTS - 1);

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    t_status             r_status, n_status;
    logic [SLOT_W-1:0]   r_scan_idx, n_scan_idx;
    logic                r_smp;
    logic [SLOT_W-1:0]   r_smp_idx;
    logic                r_keep, n_keep;
    logic [SEQ_W-1:0]    r_owner, n_owner;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out_data;
    logic [SEQ_W-1:0]    r_highest;
    logic [MASK_W-1:0]   r_visible;

    logic [1:0]          in_op;
    logic [SEQ_W-1:0]    in_seq;
    logic [SLOT_W-1:0]   top;
    logic                out_load;
    logic                mem_wr_en, mem_rd_en;
    logic [SLOT_W-1:0]   mem_rd_addr;
    t_entry              mem_wr_data, mem_rd_data;
    t_scan_ctl           scan_ctl;
    t_scan_res           scan_res;

    assign in_op  = s_axis_tdata[1:0];
    assign in_seq = s_axis_tdata[7:2];

    assign top = ({1'b0, r_highest} > LAST_SLOT) ? LAST_SLOT[SLOT_W-1:0]
                                                 : r_highest[SLOT_W-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    dwls_slot_mem #(
        .DEPTH (SEQ_SLOTS),
        .AW    (SLOT_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_seq[SLOT_W-1:0]),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    dwls_scan u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_entry (mem_rd_data),
        .o_res   (scan_res)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_seq       = r_seq;
        n_status    = r_status;
        n_scan_idx  = r_scan_idx;
        n_keep      = r_keep;
        n_owner     = r_owner;
        out_load    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_seq[SLOT_W-1:0];

        scan_ctl.clr = 1'b0;
        scan_ctl.smp = r_smp;
        scan_ctl.idx = SEQ_W'(r_smp_idx);
        scan_ctl.vis = r_visible[r_smp_idx];

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op  = in_op;
                    n_seq = in_seq;
                    if (in_op > OP_END) begin
                        n_status = STAT_BAD_CMD;
                        n_state  = S_OUT;
                    end else if (in_seq > r_highest || {1'b0, in_seq} > LAST_SLOT) begin
                        n_status = STAT_BAD_SEQ;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                mem_rd_en = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                scan_ctl.clr = 1'b1;
                n_scan_idx   = '0;
                if (r_op == OP_END) begin
                    if (!mem_rd_data.open) begin
                        n_status = STAT_UNMATCHED;
                        n_state  = S_OUT;
                    end else begin
                        mem_wr_en = 1'b1;
                        n_status  = STAT_OK;
                        n_state   = S_SCAN;
                    end
                end else if (mem_rd_data.open) begin
                    n_status = mem_rd_data.is_ins ? STAT_INS_OPEN : STAT_DEL_OPEN;
                    n_state  = S_OUT;
                end else begin
                    mem_wr_en          = 1'b1;
                    mem_wr_data.open   = 1'b1;
                    mem_wr_data.is_ins = (r_op == OP_INSERT);
                    n_status           = STAT_OK;
                    n_state            = S_SCAN;
                end
            end
            S_SCAN: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_scan_idx;
                if (r_scan_idx == top) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scan_idx = r_scan_idx + SLOT_W'(1);
                end
            end
            S_DRAIN: begin
                // last read beat is folded in at the end of this cycle
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_keep = scan_res.keep;
                if (scan_res.keep) begin
                    n_owner = scan_res.owner;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_keep    <= 1'b0;
            r_owner   <= '0;
            r_out_vld <= 1'b0;
            r_smp     <= 1'b0;
            r_highest <= 6'd63;
            r_visible <= '0;
        end else begin
            r_state <= n_state;
            r_keep  <= n_keep;
            r_owner <= n_owner;
            r_smp   <= (r_state == S_SCAN);
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HIGHEST_SEQ:  r_highest <= i_cfg_data[SEQ_W-1:0];
                    CFG_VISIBLE_MASK: r_visible <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_seq      <= n_seq;
        r_status   <= n_status;
        r_scan_idx <= n_scan_idx;
        r_smp_idx  <= r_scan_idx;
        if (out_load) begin
            r_out_data <= {(OUT_W-10)'(0), r_owner, r_keep, r_status};
        end
    end

    // a kept decision always comes from a visible insert above sequence zero
    a_keep_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_keep |-> r_owner != '0)
        else $error("keep flag set with owner zero");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_scan_idx <= top)
        else $error("scan index ran past top");

    a_drain_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN |=> r_state == S_DECIDE && r_status == STAT_OK)
        else $error("rescan entered on a rejected event");

    a_err_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status != STAT_OK && $past(r_state) != S_OUT)
            |-> $stable(r_keep) && $stable(r_owner))
        else $error("rejected event changed the decision");

endmodule
